// File: sv/gcva_pkg.sv
// Shared types and constants for the gravity-compensated vertical acceleration block.
// Holds the controller-to-datapath command and status structs. No dependencies.
package gcva_pkg;

    localparam int unsigned DecayW = 24;
    localparam logic [DecayW-1:0] DECAY_RESET = 24'd1977920;
    localparam logic signed [19:0] GRAV_RESET = 20'sd65536;
    localparam logic [31:0] EXP_NEG1_Q32 = 32'd1580030169;
    localparam logic [3:0] TAYLOR_LAST = 4'd13;
    localparam logic [3:0] EXP_INT_LIMIT = 4'd12;
    localparam logic [4:0] STEP_LAST = 5'd31;

    // Datapath micro-operations.
    typedef enum logic [4:0] {
        OP_NOP, OP_MUL, OP_W_QX2, OP_W_QY2, OP_W_QZ2, OP_RAD_Q, OP_SQ_STEP, OP_W_QW,
        OP_ACC_LD, OP_ACC_ADD, OP_W_CX, OP_W_CY, OP_CZ1, OP_CZ2, OP_W_CZ, OP_W_AWZ,
        OP_RAD_A, OP_W_TOT, OP_W_E, OP_DIV_LD, OP_DIV_FIX, OP_TERM_WR, OP_W_SE,
        OP_F_RND, OP_F_ZERO, OP_DIFF, OP_FIN
    } op_t;

    // Operand pairs for the shared multiplier.
    typedef enum logic [4:0] {
        MS_QXX, MS_QYY, MS_QZZ, MS_QXZ, MS_QWY, MS_QYZ, MS_QWX, MS_QWW,
        MS_CXAX, MS_CYAY, MS_CZAZ, MS_AXX, MS_AYY, MS_AZZ, MS_E, MS_TF, MS_SE, MS_DF,
        MS_REC
    } msel_t;

    typedef struct packed {
        op_t         op;
        msel_t       msel;
        logic [3:0]  k;
    } cmd_t;

    typedef struct packed {
        logic        sample_ok;
        logic        e_big;
        logic [3:0]  e_int;
        logic        out_free;
    } stat_t;

endpackage

// File: sv/gcva_ctrl.sv
// Sequencing controller for the gravity-compensated vertical acceleration block.
// Depends on gcva_pkg for the command and status structs.
module gcva_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  gcva_pkg::stat_t stat,
    output gcva_pkg::cmd_t  cmd
);
    import gcva_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE, ST_CHECK, ST_M_QXX, ST_W_QX2, ST_M_QYY, ST_W_QY2, ST_M_QZZ, ST_W_QZ2,
        ST_RAD_Q, ST_SQ_Q, ST_W_QW, ST_M_QXZ, ST_LD_CX, ST_M_QWY, ST_W_CX, ST_M_QYZ,
        ST_LD_CY, ST_M_QWX, ST_W_CY, ST_M_QWW, ST_CZ1, ST_CZ2, ST_W_CZ, ST_M_CXAX,
        ST_LD_AW, ST_M_CYAY, ST_ADD_AW, ST_M_CZAZ, ST_W_AWZ, ST_M_AXX, ST_LD_T, ST_M_AYY,
        ST_ADD_T, ST_M_AZZ, ST_RAD_A, ST_SQ_A, ST_W_TOT, ST_M_E, ST_W_E, ST_E_BR,
        ST_M_TF, ST_DIV_LD, ST_M_REC, ST_DIV, ST_TERM, ST_POW_LD, ST_POW_BR, ST_M_SE,
        ST_W_SE, ST_F_RND, ST_F_ZERO, ST_DIFF, ST_M_DF, ST_WAIT, ST_FIN
    } state_t;

    state_t     state_reg;
    logic       ready_reg;
    logic [4:0] cnt_reg;
    logic [3:0] k_reg;
    logic [3:0] pow_reg;

    assign s_ready = ready_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
            cnt_reg   <= '0;
            k_reg     <= '0;
            pow_reg   <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && ready_reg) begin
                        ready_reg <= 1'b0;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (stat.sample_ok) begin
                        state_reg <= ST_M_QXX;
                    end else begin
                        ready_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_M_QXX:  state_reg <= ST_W_QX2;
                ST_W_QX2:  state_reg <= ST_M_QYY;
                ST_M_QYY:  state_reg <= ST_W_QY2;
                ST_W_QY2:  state_reg <= ST_M_QZZ;
                ST_M_QZZ:  state_reg <= ST_W_QZ2;
                ST_W_QZ2:  state_reg <= ST_RAD_Q;
                ST_RAD_Q:  state_reg <= ST_SQ_Q;
                ST_SQ_Q: begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == STEP_LAST) begin
                        state_reg <= ST_W_QW;
                    end
                end
                ST_W_QW:   state_reg <= ST_M_QXZ;
                ST_M_QXZ:  state_reg <= ST_LD_CX;
                ST_LD_CX:  state_reg <= ST_M_QWY;
                ST_M_QWY:  state_reg <= ST_W_CX;
                ST_W_CX:   state_reg <= ST_M_QYZ;
                ST_M_QYZ:  state_reg <= ST_LD_CY;
                ST_LD_CY:  state_reg <= ST_M_QWX;
                ST_M_QWX:  state_reg <= ST_W_CY;
                ST_W_CY:   state_reg <= ST_M_QWW;
                ST_M_QWW:  state_reg <= ST_CZ1;
                ST_CZ1:    state_reg <= ST_CZ2;
                ST_CZ2:    state_reg <= ST_W_CZ;
                ST_W_CZ:   state_reg <= ST_M_CXAX;
                ST_M_CXAX: state_reg <= ST_LD_AW;
                ST_LD_AW:  state_reg <= ST_M_CYAY;
                ST_M_CYAY: state_reg <= ST_ADD_AW;
                ST_ADD_AW: state_reg <= ST_M_CZAZ;
                ST_M_CZAZ: state_reg <= ST_W_AWZ;
                ST_W_AWZ:  state_reg <= ST_M_AXX;
                ST_M_AXX:  state_reg <= ST_LD_T;
                ST_LD_T:   state_reg <= ST_M_AYY;
                ST_M_AYY:  state_reg <= ST_ADD_T;
                ST_ADD_T:  state_reg <= ST_M_AZZ;
                ST_M_AZZ:  state_reg <= ST_RAD_A;
                ST_RAD_A:  state_reg <= ST_SQ_A;
                ST_SQ_A: begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == STEP_LAST) begin
                        state_reg <= ST_W_TOT;
                    end
                end
                ST_W_TOT:  state_reg <= ST_M_E;
                ST_M_E:    state_reg <= ST_W_E;
                ST_W_E:    state_reg <= ST_E_BR;
                ST_E_BR: begin
                    if (stat.e_big) begin
                        state_reg <= ST_F_ZERO;
                    end else begin
                        k_reg     <= 4'd2;
                        state_reg <= ST_M_TF;
                    end
                end
                ST_M_TF:   state_reg <= ST_DIV_LD;
                ST_DIV_LD: state_reg <= ST_M_REC;
                ST_M_REC:  state_reg <= ST_DIV;
                ST_DIV:    state_reg <= ST_TERM;
                ST_TERM: begin
                    if (k_reg == TAYLOR_LAST) begin
                        state_reg <= ST_POW_LD;
                    end else begin
                        k_reg     <= k_reg + 4'd1;
                        state_reg <= ST_M_TF;
                    end
                end
                ST_POW_LD: begin
                    pow_reg   <= stat.e_int;
                    state_reg <= ST_POW_BR;
                end
                ST_POW_BR: begin
                    if (pow_reg == 4'd0) begin
                        state_reg <= ST_F_RND;
                    end else begin
                        state_reg <= ST_M_SE;
                    end
                end
                ST_M_SE:   state_reg <= ST_W_SE;
                ST_W_SE: begin
                    pow_reg   <= pow_reg - 4'd1;
                    state_reg <= ST_POW_BR;
                end
                ST_F_RND:  state_reg <= ST_DIFF;
                ST_F_ZERO: state_reg <= ST_DIFF;
                ST_DIFF:   state_reg <= ST_M_DF;
                ST_M_DF:   state_reg <= ST_WAIT;
                ST_WAIT: begin
                    if (stat.out_free) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    ready_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: begin
                    ready_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        cmd.op   = OP_NOP;
        cmd.msel = MS_QXX;
        cmd.k    = k_reg;
        unique case (state_reg)
            ST_M_QXX:  begin cmd.op = OP_MUL; cmd.msel = MS_QXX; end
            ST_M_QYY:  begin cmd.op = OP_MUL; cmd.msel = MS_QYY; end
            ST_M_QZZ:  begin cmd.op = OP_MUL; cmd.msel = MS_QZZ; end
            ST_M_QXZ:  begin cmd.op = OP_MUL; cmd.msel = MS_QXZ; end
            ST_M_QWY:  begin cmd.op = OP_MUL; cmd.msel = MS_QWY; end
            ST_M_QYZ:  begin cmd.op = OP_MUL; cmd.msel = MS_QYZ; end
            ST_M_QWX:  begin cmd.op = OP_MUL; cmd.msel = MS_QWX; end
            ST_M_QWW:  begin cmd.op = OP_MUL; cmd.msel = MS_QWW; end
            ST_M_CXAX: begin cmd.op = OP_MUL; cmd.msel = MS_CXAX; end
            ST_M_CYAY: begin cmd.op = OP_MUL; cmd.msel = MS_CYAY; end
            ST_M_CZAZ: begin cmd.op = OP_MUL; cmd.msel = MS_CZAZ; end
            ST_M_AXX:  begin cmd.op = OP_MUL; cmd.msel = MS_AXX; end
            ST_M_AYY:  begin cmd.op = OP_MUL; cmd.msel = MS_AYY; end
            ST_M_AZZ:  begin cmd.op = OP_MUL; cmd.msel = MS_AZZ; end
            ST_M_E:    begin cmd.op = OP_MUL; cmd.msel = MS_E; end
            ST_M_TF:   begin cmd.op = OP_MUL; cmd.msel = MS_TF; end
            ST_M_REC:  begin cmd.op = OP_MUL; cmd.msel = MS_REC; end
            ST_M_SE:   begin cmd.op = OP_MUL; cmd.msel = MS_SE; end
            ST_M_DF:   begin cmd.op = OP_MUL; cmd.msel = MS_DF; end
            ST_W_QX2:  cmd.op = OP_W_QX2;
            ST_W_QY2:  cmd.op = OP_W_QY2;
            ST_W_QZ2:  cmd.op = OP_W_QZ2;
            ST_RAD_Q:  cmd.op = OP_RAD_Q;
            ST_SQ_Q:   cmd.op = OP_SQ_STEP;
            ST_SQ_A:   cmd.op = OP_SQ_STEP;
            ST_W_QW:   cmd.op = OP_W_QW;
            ST_LD_CX:  cmd.op = OP_ACC_LD;
            ST_LD_CY:  cmd.op = OP_ACC_LD;
            ST_LD_AW:  cmd.op = OP_ACC_LD;
            ST_LD_T:   cmd.op = OP_ACC_LD;
            ST_ADD_AW: cmd.op = OP_ACC_ADD;
            ST_ADD_T:  cmd.op = OP_ACC_ADD;
            ST_W_CX:   cmd.op = OP_W_CX;
            ST_W_CY:   cmd.op = OP_W_CY;
            ST_CZ1:    cmd.op = OP_CZ1;
            ST_CZ2:    cmd.op = OP_CZ2;
            ST_W_CZ:   cmd.op = OP_W_CZ;
            ST_W_AWZ:  cmd.op = OP_W_AWZ;
            ST_RAD_A:  cmd.op = OP_RAD_A;
            ST_W_TOT:  cmd.op = OP_W_TOT;
            ST_W_E:    cmd.op = OP_W_E;
            ST_DIV_LD: cmd.op = OP_DIV_LD;
            ST_DIV:    cmd.op = OP_DIV_FIX;
            ST_TERM:   cmd.op = OP_TERM_WR;
            ST_W_SE:   cmd.op = OP_W_SE;
            ST_F_RND:  cmd.op = OP_F_RND;
            ST_F_ZERO: cmd.op = OP_F_ZERO;
            ST_DIFF:   cmd.op = OP_DIFF;
            ST_FIN:    cmd.op = OP_FIN;
            default:   cmd.op = OP_NOP;
        endcase
    end

endmodule

// File: sv/gcva_dp.sv
// Datapath for the gravity-compensated vertical acceleration block: one shared
// multiplier, accumulator, square-root and small-divisor units, state and output registers.
// Depends on gcva_pkg.
module gcva_dp (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic                  s_fifo_ok,
    input  logic                  s_has_quat,
    input  logic                  s_has_accel,
    input  logic signed [31:0]    s_quat_x,
    input  logic signed [31:0]    s_quat_y,
    input  logic signed [31:0]    s_quat_z,
    input  logic signed [15:0]    s_accel_x,
    input  logic signed [15:0]    s_accel_y,
    input  logic signed [15:0]    s_accel_z,
    input  logic [31:0]           s_time_ms,
    input  logic                  cfg_wr_en,
    input  logic [gcva_pkg::DecayW-1:0] cfg_wr_data,
    input  gcva_pkg::cmd_t        cmd,
    output gcva_pkg::stat_t       stat,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [20:0]    m_vertical_accel,
    output logic [18:0]           m_total_accel,
    output logic signed [19:0]    m_gravity_level
);
    import gcva_pkg::*;

    // Sample and state registers.
    logic               ok_reg;
    logic signed [31:0] qx_reg, qy_reg, qz_reg;
    logic signed [15:0] ax_reg, ay_reg, az_reg;
    logic [31:0]        time_reg, dt_reg, last_time_reg;
    logic [DecayW-1:0]  decay_reg;
    logic signed [19:0] grav_reg;

    // Working registers.
    logic signed [68:0] prod_reg;
    logic signed [66:0] acc_reg;
    logic [62:0]        qx2_reg, qy2_reg, qz2_reg;
    logic [63:0]        sq_v_reg, sq_r_reg, sq_b_reg;
    logic [30:0]        qw_reg;
    logic signed [34:0] cx_reg, cy_reg, cz_reg;
    logic signed [24:0] awz_reg;
    logic [18:0]        tot_reg;
    logic [55:0]        e_reg;
    logic [31:0]        term_reg, div_num_reg;
    logic signed [33:0] sum_reg;
    logic [16:0]        f_reg;
    logic signed [25:0] diff_reg;

    // Result registers.
    logic               out_valid_reg;
    logic signed [20:0] out_vert_reg;
    logic [18:0]        out_tot_reg;

    logic signed [34:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [68:0] prod_next;

    logic [63:0]        msum;
    logic [63:0]        sq_rb;
    logic [31:0]        q_est;
    logic [35:0]        q_k;
    logic [35:0]        rem_w;
    logic signed [69:0] wide;
    logic signed [66:0] acc_t;
    logic [32:0]        f_t;
    logic signed [52:0] rnd_t;
    logic signed [26:0] ng_t;
    logic signed [25:0] vert_t;

    // Reciprocals floor((2^35 - 1) / k) of the series divisors. The product with a
    // 32-bit numerator, shifted down by 35, is the quotient or one less.
    function automatic logic [33:0] recip_of(input logic [3:0] k);
        unique case (k)
            4'd2:    return 34'd17179869183;
            4'd3:    return 34'd11453246122;
            4'd4:    return 34'd8589934591;
            4'd5:    return 34'd6871947673;
            4'd6:    return 34'd5726623061;
            4'd7:    return 34'd4908534052;
            4'd8:    return 34'd4294967295;
            4'd9:    return 34'd3817748707;
            4'd10:   return 34'd3435973836;
            4'd11:   return 34'd3123612578;
            4'd12:   return 34'd2863311530;
            4'd13:   return 34'd2643056797;
            default: return '0;
        endcase
    endfunction

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.msel)
            MS_QXX:  begin mul_a = 35'(qx_reg); mul_b = 34'(qx_reg); end
            MS_QYY:  begin mul_a = 35'(qy_reg); mul_b = 34'(qy_reg); end
            MS_QZZ:  begin mul_a = 35'(qz_reg); mul_b = 34'(qz_reg); end
            MS_QXZ:  begin mul_a = 35'(qx_reg); mul_b = 34'(qz_reg); end
            MS_QWY:  begin mul_a = $signed({4'd0, qw_reg}); mul_b = 34'(qy_reg); end
            MS_QYZ:  begin mul_a = 35'(qy_reg); mul_b = 34'(qz_reg); end
            MS_QWX:  begin mul_a = $signed({4'd0, qw_reg}); mul_b = 34'(qx_reg); end
            MS_QWW:  begin mul_a = $signed({4'd0, qw_reg}); mul_b = $signed({3'd0, qw_reg}); end
            MS_CXAX: begin mul_a = cx_reg; mul_b = 34'(ax_reg); end
            MS_CYAY: begin mul_a = cy_reg; mul_b = 34'(ay_reg); end
            MS_CZAZ: begin mul_a = cz_reg; mul_b = 34'(az_reg); end
            MS_AXX:  begin mul_a = 35'(ax_reg); mul_b = 34'(ax_reg); end
            MS_AYY:  begin mul_a = 35'(ay_reg); mul_b = 34'(ay_reg); end
            MS_AZZ:  begin mul_a = 35'(az_reg); mul_b = 34'(az_reg); end
            MS_E:    begin mul_a = $signed({11'd0, decay_reg}); mul_b = $signed({2'd0, dt_reg}); end
            MS_TF:   begin mul_a = $signed({3'd0, term_reg}); mul_b = $signed({2'd0, e_reg[31:0]}); end
            MS_REC:  begin
                mul_a = $signed({1'b0, recip_of(cmd.k)});
                mul_b = $signed({2'd0, div_num_reg});
            end
            MS_SE:   begin mul_a = 35'(sum_reg); mul_b = $signed({2'd0, EXP_NEG1_Q32}); end
            MS_DF:   begin mul_a = 35'(diff_reg); mul_b = $signed({17'd0, f_reg}); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
        prod_next = 69'(mul_a) * 69'(mul_b);
    end

    always_comb begin
        msum   = 64'(qx2_reg) + 64'(qy2_reg) + 64'(qz2_reg);
        sq_rb  = sq_r_reg + sq_b_reg;
        q_est  = prod_reg[66:35];
        q_k    = 36'(q_est) * 36'(cmd.k);
        rem_w  = 36'(div_num_reg) - q_k;
        wide   = 70'(acc_reg) - 70'(prod_reg);
        acc_t  = acc_reg + 67'(prod_reg);
        f_t    = 33'(sum_reg) + 33'd32768;
        rnd_t  = 53'((prod_reg + 69'sd32768) >>> 16);
        ng_t   = 27'(awz_reg) + 27'(rnd_t);
        vert_t = 26'(awz_reg) - 26'(grav_reg);
    end

    assign stat.sample_ok = ok_reg;
    assign stat.e_big     = (e_reg[55:32] >= 24'(EXP_INT_LIMIT));
    assign stat.e_int     = e_reg[35:32];
    assign stat.out_free  = !out_valid_reg || m_ready;

    assign m_valid          = out_valid_reg;
    assign m_vertical_accel = out_vert_reg;
    assign m_total_accel    = out_tot_reg;
    assign m_gravity_level  = grav_reg;

    // Control state: configuration, estimator state, result handshake.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decay_reg     <= DECAY_RESET;
            grav_reg      <= GRAV_RESET;
            last_time_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                decay_reg <= cfg_wr_data;
            end
            if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.op == OP_FIN) begin
                out_valid_reg <= 1'b1;
                last_time_reg <= time_reg;
                if (ng_t > 27'sd524287) begin
                    grav_reg <= 20'sd524287;
                end else if (ng_t < -27'sd524288) begin
                    grav_reg <= -20'sd524288;
                end else begin
                    grav_reg <= 20'(ng_t);
                end
            end
        end
    end

    // Payload and working registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            ok_reg   <= s_fifo_ok && s_has_quat && s_has_accel;
            qx_reg   <= s_quat_x;
            qy_reg   <= s_quat_y;
            qz_reg   <= s_quat_z;
            ax_reg   <= s_accel_x;
            ay_reg   <= s_accel_y;
            az_reg   <= s_accel_z;
            time_reg <= s_time_ms;
            dt_reg   <= s_time_ms - last_time_reg;
        end
        case (cmd.op)
            OP_MUL:    prod_reg <= prod_next;
            OP_W_QX2:  qx2_reg <= prod_reg[62:0];
            OP_W_QY2:  qy2_reg <= prod_reg[62:0];
            OP_W_QZ2:  qz2_reg <= prod_reg[62:0];
            OP_RAD_Q: begin
                // Clamp the squared length of the vector part to one.
                if (msum > 64'(1) << 60) begin
                    sq_v_reg <= '0;
                end else begin
                    sq_v_reg <= (64'(1) << 60) - msum;
                end
                sq_r_reg <= '0;
                sq_b_reg <= 64'(1) << 62;
            end
            OP_SQ_STEP: begin
                if (sq_v_reg >= sq_rb) begin
                    sq_v_reg <= sq_v_reg - sq_rb;
                    sq_r_reg <= (sq_r_reg >> 1) + sq_b_reg;
                end else begin
                    sq_r_reg <= sq_r_reg >> 1;
                end
                sq_b_reg <= sq_b_reg >> 2;
            end
            OP_W_QW:   qw_reg <= sq_r_reg[30:0];
            OP_ACC_LD: acc_reg <= 67'(prod_reg);
            OP_ACC_ADD: acc_reg <= acc_t;
            OP_W_CX:   cx_reg <= 35'(wide >>> 29);
            OP_W_CY:   cy_reg <= 35'((70'(acc_reg) + 70'(prod_reg)) >>> 29);
            OP_CZ1:    acc_reg <= 67'(prod_reg) - $signed({4'd0, qx2_reg});
            OP_CZ2:    acc_reg <= acc_reg - $signed({4'd0, qy2_reg});
            OP_W_CZ:   cz_reg <= 35'((acc_reg + $signed({4'd0, qz2_reg})) >>> 30);
            OP_W_AWZ:  awz_reg <= 25'((acc_t + 67'sd67108864) >>> 27);
            OP_RAD_A: begin
                sq_v_reg <= {26'd0, acc_t[31:0], 6'd0};
                sq_r_reg <= '0;
                sq_b_reg <= 64'(1) << 62;
            end
            OP_W_TOT: begin
                if (sq_r_reg > 64'd524287) begin
                    tot_reg <= 19'h7FFFF;
                end else begin
                    tot_reg <= sq_r_reg[18:0];
                end
            end
            OP_W_E: begin
                // The first series term is the fractional part itself.
                e_reg    <= prod_reg[55:0];
                term_reg <= prod_reg[31:0];
                sum_reg  <= 34'sh100000000 - $signed({2'd0, prod_reg[31:0]});
            end
            OP_DIV_LD: begin
                div_num_reg <= prod_reg[63:32];
            end
            OP_DIV_FIX: begin
                // The reciprocal estimate is low by at most one.
                if (rem_w >= 36'(cmd.k)) begin
                    div_num_reg <= q_est + 32'd1;
                end else begin
                    div_num_reg <= q_est;
                end
            end
            OP_TERM_WR: begin
                term_reg <= div_num_reg;
                if (cmd.k[0]) begin
                    sum_reg <= sum_reg - $signed({2'd0, div_num_reg});
                end else begin
                    sum_reg <= sum_reg + $signed({2'd0, div_num_reg});
                end
            end
            OP_W_SE:   sum_reg <= $signed({1'b0, prod_reg[64:32]});
            OP_F_RND:  f_reg <= f_t[32:16];
            OP_F_ZERO: f_reg <= '0;
            OP_DIFF:   diff_reg <= 26'(grav_reg) - 26'(awz_reg);
            OP_FIN: begin
                out_tot_reg <= tot_reg;
                if (vert_t > 26'sd1048575) begin
                    out_vert_reg <= 21'sd1048575;
                end else if (vert_t < -26'sd1048576) begin
                    out_vert_reg <= -21'sd1048576;
                end else begin
                    out_vert_reg <= 21'(vert_t);
                end
            end
            default: ;
        endcase
    end

endmodule

// File: sv/gravity_compensated_vertical_accel.sv
// Top level of the gravity-compensated vertical acceleration block.
// Joins gcva_ctrl (sequencer) and gcva_dp (datapath); depends on gcva_pkg.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid / s_ready  flags, quat_x/y/z Q30, accel_x/y/z Q13, time_ms
//   m_        out        m_valid / m_ready  vertical_accel Q16, total_accel Q16, gravity_level
//   cfg_      in         cfg_wr_en          cfg_wr_data: decay_rate, Q0.32 per millisecond
//
// One request is processed at a time through a single shared multiplier. A request
// runs the two 32-step square roots; unless decay_rate times the interval reaches 12,
// it also runs the twelve exp() series terms and one exp(-1) factor per whole unit of
// the exponent.
// A request with a cleared flag is dropped in the check state that follows its capture.
// Reset (aresetn low, synchronous) restores decay_rate, a gravity estimate of 1 g and a
// last time of zero. A waiting result does not block the next request: the block stalls
// only at its final step while the output register is still full.
module gravity_compensated_vertical_accel (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_fifo_ok,
    input  logic                         s_has_quat,
    input  logic                         s_has_accel,
    input  logic signed [31:0]           s_quat_x,
    input  logic signed [31:0]           s_quat_y,
    input  logic signed [31:0]           s_quat_z,
    input  logic signed [15:0]           s_accel_x,
    input  logic signed [15:0]           s_accel_y,
    input  logic signed [15:0]           s_accel_z,
    input  logic [31:0]                  s_time_ms,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [20:0]           m_vertical_accel,
    output logic [18:0]                  m_total_accel,
    output logic signed [19:0]           m_gravity_level,
    input  logic                         cfg_wr_en,
    input  logic [gcva_pkg::DecayW-1:0]  cfg_wr_data
);
    import gcva_pkg::*;

    cmd_t cmd;
    stat_t stat;
    logic accept;

    // The datapath captures a sample on every accepted request; the controller
    // then decides from the captured flags whether it produces a result.
    assign accept = s_valid && s_ready;

    gcva_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    gcva_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .accept           (accept),
        .s_fifo_ok        (s_fifo_ok),
        .s_has_quat       (s_has_quat),
        .s_has_accel      (s_has_accel),
        .s_quat_x         (s_quat_x),
        .s_quat_y         (s_quat_y),
        .s_quat_z         (s_quat_z),
        .s_accel_x        (s_accel_x),
        .s_accel_y        (s_accel_y),
        .s_accel_z        (s_accel_z),
        .s_time_ms        (s_time_ms),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .cmd              (cmd),
        .stat             (stat),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_vertical_accel (m_vertical_accel),
        .m_total_accel    (m_total_accel),
        .m_gravity_level  (m_gravity_level)
    );

endmodule

// File: test/tb_gravity_compensated_vertical_accel.sv
`timescale 1ns / 1ps
// Self-checking testbench for gravity_compensated_vertical_accel.
// A clocked driver and monitor run against an in-bench predictor; depends on gcva_pkg.
module tb_gravity_compensated_vertical_accel;
    import gcva_pkg::*;

    localparam int MaxCycles = 2000000;
    // Covers the slowest request: two square roots, the exp() series and the drop path.
    localparam int DrainCycles = 700;

    // One motion sample as it is offered on the request channel.
    typedef struct packed {
        logic               fifo_ok;
        logic               has_quat;
        logic               has_accel;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic [31:0]        time_ms;
    } sample_t;

    // One result of the block.
    typedef struct packed {
        logic signed [20:0] vertical_accel;
        logic [18:0]        total_accel;
        logic signed [19:0] gravity_level;
    } accel_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [20:0] m_vertical_accel;
    logic [18:0] m_total_accel;
    logic signed [19:0] m_gravity_level;
    logic cfg_wr_en = 1'b0;
    logic [DecayW-1:0] cfg_wr_data = '0;
    sample_t drive_sample = '0;

    // Samples waiting for the driver, and results the predictor still owes the monitor.
    sample_t pending_samples[$];
    accel_result_t expected_results[$];

    // Predictor state, a copy of what the block holds.
    logic [DecayW-1:0] model_decay;
    logic signed [19:0] model_gravity;
    logic [31:0] model_last_ms;

    int mismatch_count = 0;
    int results_seen = 0;
    int requests_taken = 0;
    int dropped_requests = 0;
    int cycle_count = 0;
    logic req_taken = 1'b0;
    logic quiet = 1'b0;
    logic [31:0] clock_ms = 32'd0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    gravity_compensated_vertical_accel i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_fifo_ok       (drive_sample.fifo_ok),
        .s_has_quat      (drive_sample.has_quat),
        .s_has_accel     (drive_sample.has_accel),
        .s_quat_x        (drive_sample.quat_x),
        .s_quat_y        (drive_sample.quat_y),
        .s_quat_z        (drive_sample.quat_z),
        .s_accel_x       (drive_sample.accel_x),
        .s_accel_y       (drive_sample.accel_y),
        .s_accel_z       (drive_sample.accel_z),
        .s_time_ms       (drive_sample.time_ms),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_vertical_accel(m_vertical_accel),
        .m_total_accel   (m_total_accel),
        .m_gravity_level (m_gravity_level),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data)
    );

    // Bit-by-bit integer square root, floor of the true root.
    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Averaging weight exp(-x) for x in Q32, returned in Q16. The integer part of x
    // is applied as repeated factors of exp(-1), the fraction by a Taylor series.
    function automatic logic [16:0] decay_weight(input logic [63:0] x);
        logic [63:0] fr;
        logic [63:0] term;
        logic [63:0] s;
        longint sum;
        int int_part;
        if (x >= (64'd12 << 32)) return '0;
        int_part = int'(x[63:32]);
        fr = {32'b0, x[31:0]};
        term = 64'h1_0000_0000;
        sum = longint'(64'h1_0000_0000);
        for (int k = 1; k <= 13; k++) begin
            term = ((term * fr) >> 32) / 64'(k);
            if (k % 2 == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
        end
        s = 64'(sum);
        for (int j = 0; j < int_part; j++) s = (s * {32'b0, EXP_NEG1_Q32}) >> 32;
        s = (s + 64'd32768) >> 16;
        return s[16:0];
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Works out the result of one valid sample and advances the gravity estimate.
    function automatic accel_result_t predict_vertical(input sample_t smp);
        accel_result_t res;
        longint qx, qy, qz, qw, ax, ay, az, cx, cy, cz, awz, mag, g, ng, tot;
        logic [31:0] dt;
        logic [63:0] expo;
        logic [16:0] f;
        qx = longint'(smp.quat_x);
        qy = longint'(smp.quat_y);
        qz = longint'(smp.quat_z);
        ax = longint'(smp.accel_x);
        ay = longint'(smp.accel_y);
        az = longint'(smp.accel_z);
        dt = smp.time_ms - model_last_ms;
        expo = {40'b0, model_decay} * {32'b0, dt};
        f = decay_weight(expo);

        // Rebuild the scalar part, treating an over-long vector as unit length.
        mag = qx * qx + qy * qy + qz * qz;
        if (mag > (longint'(1) << 60)) mag = longint'(1) << 60;
        qw = longint'(int_sqrt(64'((longint'(1) << 60) - mag)));

        // Row of the rotation matrix that yields world z, in Q30.
        cx = (qx * qz - qw * qy) >>> 29;
        cy = (qy * qz + qw * qx) >>> 29;
        cz = (((qw * qw - qx * qx) - qy * qy) + qz * qz) >>> 30;
        awz = (cx * ax + cy * ay + cz * az + (longint'(1) << 26)) >>> 27;

        tot = longint'(int_sqrt(64'((ax * ax + ay * ay + az * az) << 6)));
        if (tot > 524287) tot = 524287;

        g = longint'(model_gravity);
        ng = awz + (((g - awz) * longint'({47'b0, f}) + 32768) >>> 16);
        ng = clamp(ng, -524288, 524287);

        res.vertical_accel = 21'(clamp(awz - g, -1048576, 1048575));
        res.total_accel = 19'(tot);
        res.gravity_level = 20'(ng);
        model_gravity = 20'(ng);
        model_last_ms = smp.time_ms;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatch_count < 40)
            $display("MISMATCH at result %0d: %s got %0d, expected %0d",
                     results_seen, what, got, want);
        mismatch_count++;
    endtask

    // Predictor and monitor. Requests and configuration writes are sampled at the
    // same edge the block sees them, so the model follows the block exactly.
    always @(posedge aclk) begin
        accel_result_t want;
        cycle_count++;
        if (cycle_count > MaxCycles) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
        if (!aresetn) begin
            model_decay = DECAY_RESET;
            model_gravity = GRAV_RESET;
            model_last_ms = '0;
            req_taken <= 1'b0;
        end else begin
            req_taken <= s_valid && s_ready;
            if (cfg_wr_en) model_decay = cfg_wr_data;
            if (s_valid && s_ready) begin
                requests_taken++;
                if (drive_sample.fifo_ok && drive_sample.has_quat && drive_sample.has_accel)
                    expected_results.push_back(predict_vertical(drive_sample));
                else
                    dropped_requests++;
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing expected", 1, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_vertical_accel !== want.vertical_accel)
                        report_mismatch("vertical_accel", m_vertical_accel,
                                        want.vertical_accel);
                    if (m_total_accel !== want.total_accel)
                        report_mismatch("total_accel", m_total_accel, want.total_accel);
                    if (m_gravity_level !== want.gravity_level)
                        report_mismatch("gravity_level", m_gravity_level,
                                        want.gravity_level);
                end
                results_seen++;
            end
        end
    end

    // Request driver: holds a request until it is taken, then either idles for a
    // random burst or offers the next pending sample.
    int gap_left = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_valid && !req_taken) begin
                // Still waiting for the block to take the current request.
            end else if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_samples.size() > 0 && !quiet && $urandom_range(0, 9) == 0) begin
                gap_left = $urandom_range(1, 18) - 1;
                s_valid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
                drive_sample <= pending_samples.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus one long hold-off early in the run so the
    // output register fills and the block has to stall its request side.
    int stall_left = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && results_seen >= 60) begin
                hold_done = 1'b1;
                hold_left = 2500;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 18) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic real rand_unit();
        return real'(int'($urandom_range(0, 2000000)) - 1000000) / 1.0e6;
    endfunction

    // Builds a random sample. Most are well-formed: all flags set, a unit quaternion
    // and an acceleration near 1 g, a short interval. The rest probe the edges.
    function automatic sample_t random_sample();
        sample_t smp;
        real vx, vy, vz, len, scale;
        int pick;
        smp.fifo_ok = 1'b1;
        smp.has_quat = 1'b1;
        smp.has_accel = 1'b1;
        if ($urandom_range(0, 9) == 0) {smp.fifo_ok, smp.has_quat, smp.has_accel} =
            3'($urandom_range(0, 6));

        if ($urandom_range(0, 9) == 0) begin
            // Any component in range, the vector may be longer than one.
            smp.quat_x = 32'($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
            smp.quat_y = 32'($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
            smp.quat_z = 32'($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
        end else begin
            vx = rand_unit();
            vy = rand_unit();
            vz = rand_unit();
            len = $sqrt(vx * vx + vy * vy + vz * vz) + 1.0e-9;
            scale = ($urandom_range(0, 1000) / 1000.0) / len;
            if (scale * len > 1.0) scale = 1.0 / len;
            smp.quat_x = $rtoi(vx * scale * 1073741823.0);
            smp.quat_y = $rtoi(vy * scale * 1073741823.0);
            smp.quat_z = $rtoi(vz * scale * 1073741823.0);
        end

        if ($urandom_range(0, 6) == 0) begin
            smp.accel_x = 16'($urandom);
            smp.accel_y = 16'($urandom);
            smp.accel_z = 16'($urandom);
        end else begin
            smp.accel_x = 16'(int'($urandom_range(0, 4000)) - 2000);
            smp.accel_y = 16'(int'($urandom_range(0, 4000)) - 2000);
            smp.accel_z = 16'(int'($urandom_range(0, 4000)) + 6192);
        end

        pick = $urandom_range(0, 19);
        if (pick == 0) clock_ms = $urandom;
        else if (pick == 1) clock_ms = clock_ms + $urandom_range(3000, 200000);
        else if (pick == 2) clock_ms = clock_ms;
        else clock_ms = clock_ms + $urandom_range(1, 60);
        smp.time_ms = clock_ms;
        return smp;
    endfunction

    task automatic add_sample(input logic [2:0] flags, input int qx, input int qy, input int qz,
                              input int ax, input int ay, input int az, input logic [31:0] t);
        sample_t smp;
        {smp.fifo_ok, smp.has_quat, smp.has_accel} = flags;
        smp.quat_x = qx;
        smp.quat_y = qy;
        smp.quat_z = qz;
        smp.accel_x = 16'(ax);
        smp.accel_y = 16'(ay);
        smp.accel_z = 16'(az);
        smp.time_ms = t;
        pending_samples.push_back(smp);
        clock_ms = t;
    endtask

    task automatic add_random(input int count);
        for (int n = 0; n < count; n++) pending_samples.push_back(random_sample());
    endtask

    // Lets the block go idle: every request taken, every result back, and then the
    // time a dropped request or an unfinished one would still need.
    task automatic wait_idle();
        while (pending_samples.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    task automatic write_decay(input logic [DecayW-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    localparam int Q1 = 32'sh4000_0000;
    localparam int QN1 = -32'sh4000_0000;

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset decay rate. Level device, then each cleared flag,
        // which must be dropped without moving the gravity estimate.
        add_sample(3'b111, 0, 0, 0, 0, 0, 8192, 32'd10);
        add_sample(3'b011, 0, 0, 0, 0, 0, 8192, 32'd20);
        add_sample(3'b101, 0, 0, 0, 0, 0, 8192, 32'd30);
        add_sample(3'b110, 0, 0, 0, 0, 0, 8192, 32'd40);
        add_sample(3'b000, Q1, Q1, Q1, 32767, 32767, 32767, 32'hFFFF_FFFF);
        // Same time twice: no decay at all.
        add_sample(3'b111, 0, 0, 0, 100, -100, 8000, 32'd50);
        add_sample(3'b111, 0, 0, 0, 100, -100, 8000, 32'd50);
        // Half turns about each axis: the scalar part rebuilds to zero.
        add_sample(3'b111, Q1, 0, 0, 0, 0, 8192, 32'd60);
        add_sample(3'b111, 0, QN1, 0, 0, 0, 8192, 32'd61);
        add_sample(3'b111, 0, 0, Q1, 1000, 2000, 8192, 32'd62);
        // Vector longer than one, used unnormalized; the scalar part rebuilds to zero.
        add_sample(3'b111, Q1, Q1, Q1, 32767, 32767, 32767, 32'd70);
        add_sample(3'b111, QN1, QN1, QN1, -32768, -32768, -32768, 32'd80);
        add_sample(3'b111, Q1, QN1, Q1, -32768, 32767, -32768, 32'd90);
        // Acceleration extremes with a level device.
        add_sample(3'b111, 0, 0, 0, 32767, 32767, 32767, 32'd100);
        add_sample(3'b111, 0, 0, 0, -32768, -32768, -32768, 32'd101);
        add_sample(3'b111, 0, 0, 0, 0, 0, 0, 32'd102);
        // Long interval: the weight flushes to zero and the estimate jumps.
        add_sample(3'b111, 32'sh1000_0000, 32'sh0800_0000, 0, 500, 0, 8192, 32'd200000);
        // Time wraps through zero.
        add_sample(3'b111, 0, 0, 0, 0, 0, 8192, 32'hFFFF_FFF0);
        add_sample(3'b111, 0, 0, 0, 0, 0, 8192, 32'd5);
        add_sample(3'b111, 0, 0, 0, 0, 0, 8192, 32'd4000);
        wait_idle();

        // No decay: the estimate never moves.
        write_decay('0);
        add_random(100);
        wait_idle();

        // Fastest decay: intervals of a few seconds flush the average.
        write_decay({DecayW{1'b1}});
        add_random(100);
        wait_idle();

        write_decay(DecayW'($urandom));
        add_random(150);
        wait_idle();

        // Back to the reset rate; the tail of the run has no idling on either side.
        write_decay(DECAY_RESET);
        add_random(80);
        while (pending_samples.size() != 0) @(posedge aclk);
        quiet = 1'b1;
        add_random(100);
        wait_idle();

        $display("requests taken: %0d (%0d dropped), results checked: %0d",
                 requests_taken, dropped_requests, results_seen);
        $display("decay rates covered: reset, zero, maximum and one random setting");
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
